// File: rtl/ascii85_stream_decoder_macros.svh
// Assertion macros for the ASCII85 stream decoder.
// Included by the top level; no other dependencies.
`ifndef ASCII85_STREAM_DECODER_MACROS_SVH
`define ASCII85_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define A85_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ascii85 decoder check failed");
// next-cycle implication
`define A85_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ascii85 decoder check failed");
`else
`define A85_ASSERT_IMP(label, clk, rst, ante, cons)
`define A85_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/asc85_pkg.sv
// Shared types for the ASCII85 stream decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package asc85_pkg;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       bad_char;
      logic       last_of_run;
   } rsp_type;

   // one queued group: up to four bytes, emitted from word[31:24] down
   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  last_idx;
      logic        bad;
   } grp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

`default_nettype wire

// File: rtl/asc85_fifo.sv
// Group queue between the front (classify/accumulate) and back (byte output).
// Depends on asc85_pkg.
`default_nettype none

module asc85_fifo
   import asc85_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire grp_type       wdata,
   input  wire logic          pop,
   output grp_type            head,
   output fifo_stat_type      stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   grp_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

// File: rtl/asc85_front.sv
// Front end: accepts characters, folds base-85 digits, queues byte groups.
// Depends on asc85_pkg; feeds asc85_fifo.
`default_nettype none

module asc85_front
   import asc85_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_type       req_data,
   input  wire fifo_stat_type q_stat,
   output logic               q_push,
   output grp_type            q_wdata
);

   localparam logic [7:0]  CHAR_BANG  = 8'h21;
   localparam logic [7:0]  CHAR_U     = 8'h75;
   localparam logic [7:0]  CHAR_Z     = 8'h7A;
   localparam logic [7:0]  CHAR_SPACE = 8'h20;
   localparam logic [7:0]  CHAR_TAB   = 8'h09;
   localparam logic [7:0]  CHAR_LF    = 8'h0A;
   localparam logic [7:0]  CHAR_CR    = 8'h0D;
   localparam logic [31:0] BASE       = 32'd85;
   localparam logic [2:0]  LAST_DIGIT = 3'd4;

   logic [31:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        accept;
   logic [7:0]  diff;
   logic [31:0] acc_mac;
   logic [31:0] scale;
   logic [31:0] pad_word;
   logic        is_ws;
   logic        is_digit;

   // 85^(5-n): padding n digits with 84s equals (acc+1)*85^(5-n) - 1
   always_comb begin
      unique case (cnt_ff)
         3'd2:    scale = 32'd614125;
         3'd3:    scale = 32'd7225;
         default: scale = BASE;
      endcase
   end

   always_comb begin
      accept   = req_valid && req_ready;
      diff     = req_data.char_code - CHAR_BANG;
      acc_mac  = (acc_ff * BASE) + {25'b0, diff[6:0]};
      pad_word = ((acc_ff + 32'd1) * scale) - 32'd1;
      is_ws    = (req_data.char_code == CHAR_SPACE) || (req_data.char_code == CHAR_TAB)
               || (req_data.char_code == CHAR_LF) || (req_data.char_code == CHAR_CR);
      is_digit = (req_data.char_code >= CHAR_BANG) && (req_data.char_code <= CHAR_U);

      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      q_push   = 1'b0;
      q_wdata  = '{word: '0, last_idx: 2'd3, bad: 1'b0};

      if (accept) begin
         priority if (req_data.mode) begin
            // flush: n digits give n-1 bytes
            q_push           = (cnt_ff >= 3'd2);
            q_wdata.word     = pad_word;
            q_wdata.last_idx = 2'(cnt_ff - 3'd2);
            acc_in           = '0;
            cnt_in           = '0;
         end else if (is_ws) begin
            // skip
         end else if ((req_data.char_code == CHAR_Z) && (cnt_ff == '0)) begin
            q_push = 1'b1;
         end else if (is_digit) begin
            if (cnt_ff == LAST_DIGIT) begin
               q_push       = 1'b1;
               q_wdata.word = acc_mac;
               acc_in       = '0;
               cnt_in       = '0;
            end else begin
               acc_in = acc_mac;
               cnt_in = cnt_ff + 3'd1;
            end
         end else begin
            q_push           = 1'b1;
            q_wdata.last_idx = 2'd0;
            q_wdata.bad      = 1'b1;
            acc_in           = '0;
            cnt_in           = '0;
         end
      end
   end

   assign req_ready = !q_stat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/asc85_back.sv
// Back end: splits queued groups into bytes and holds the output register.
// Depends on asc85_pkg; drains asc85_fifo.
`default_nettype none

module asc85_back
   import asc85_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire fifo_stat_type q_stat,
   input  wire grp_type       q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       load;
   logic       emit;
   logic       last;
   logic [7:0] sel_byte;

   always_comb begin
      unique case (idx_ff)
         2'd0:    sel_byte = q_head.word[31:24];
         2'd1:    sel_byte = q_head.word[23:16];
         2'd2:    sel_byte = q_head.word[15:8];
         default: sel_byte = q_head.word[7:0];
      endcase
   end

   always_comb begin
      // refill the output register when it is empty or being taken
      load  = !rsp_valid_ff || rsp_ready;
      emit  = load && !q_stat.empty;
      last  = (idx_ff == q_head.last_idx);
      q_pop = emit && last;

      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = !q_stat.empty;
      end
      if (emit) begin
         rsp_data_in = '{data_byte: sel_byte, bad_char: q_head.bad, last_of_run: last};
         idx_in      = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/ascii85_stream_decoder.sv
// ASCII85 stream decoder top level: front, group queue, back.
// Depends on asc85_pkg, asc85_front, asc85_fifo, asc85_back and the macros header.
//
//   Port group   Dir   Payload    Meaning
//   req_         in    req_type   one character or an end-of-stream word
//   rsp_         out   rsp_type   one decoded byte or a bad-character report
//
// A word is taken every cycle while the group queue has room; the base-85
// multiply-accumulate sits in the front, one per word.
// Results leave at one byte per cycle from the back's output register while
// rsp_ready is high; a five-digit group gives four bytes, and the queue of
// QUEUE_DEPTH groups absorbs the bursts and stalls the input when full.
// Reset clears the accumulator, digit count, queue and output valid.
`default_nettype none
`include "ascii85_stream_decoder_macros.svh"

module ascii85_stream_decoder
   import asc85_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   fifo_stat_type q_stat;
   logic          q_push;
   logic          q_pop;
   grp_type       q_wdata;
   grp_type       q_head;

   asc85_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   asc85_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .head  (q_head),
      .stat  (q_stat)
   );

   asc85_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `A85_ASSERT_IMP(a_bad_is_last, clock, reset, rsp_valid && rsp_data.bad_char, rsp_data.last_of_run && (rsp_data.data_byte == 8'h00))
   `A85_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid && q_stat.empty)
   `A85_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop, !q_stat.empty)

endmodule

`default_nettype wire
